>>> sv/tcpq_pkg.sv
// Shared types, sizes and codes of the two-class priority ticket queue.
// Used by the queue control, the top level and the port checker.
package tcpq_pkg;

  // queue geometry and field widths
  localparam int QUEUE_DEPTH = 64;
  localparam int ID_WIDTH    = 16;
  localparam int SEQ_W       = 16;
  localparam int CUST_W      = 16;
  localparam int COUNT_W     = 7;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W     = SEQ_W + ID_WIDTH;

  typedef logic [PTR_W-1:0]    ptr_t;
  typedef logic [FILL_W-1:0]   fill_t;
  typedef logic [SEQ_W-1:0]    seq_t;
  typedef logic [ID_WIDTH-1:0] id_t;
  typedef logic [COUNT_W-1:0]  count_t;

  // item opcodes
  typedef enum logic {
    OP_ISSUE = 1'b0,
    OP_CALL  = 1'b1
  } opcode_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_ISSUED = 2'd0,
    ST_CALLED = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // one stored queue entry
  typedef struct packed {
    seq_t seq;
    id_t  id;
  } entry_t;

  // access request to one queue memory
  typedef struct packed {
    logic   we;
    ptr_t   waddr;
    entry_t wdata;
    logic   re;
    ptr_t   raddr;
  } mem_req_t;

  // decision of one item, waiting for the memory read
  typedef struct packed {
    status_t status;
    seq_t    ticket;
    logic    from_pref;
    fill_t   pref_fill;
    fill_t   norm_fill;
  } stage_t;

  // pointer step with wrap at the queue depth
  function automatic ptr_t ptr_adv(input ptr_t p);
    ptr_adv = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + ptr_t'(1);
  endfunction

endpackage

>>> sv/two_class_priority_ticket_queue.sv
// Two-class strict-priority ticket queue.
//
// Item channel (item_valid/item_stall): opcode issue or call, class bit
// and customer id. Result channel (result_valid/result_stall): status,
// ticket, served customer and class, and both queue fill counts after the
// item. Exactly one result beat per item beat, in order.
// Issue stamps the id with the running sequence number (1 after reset,
// wraps at 16 bits) and appends it to its class queue; a full queue
// rejects. Call takes the oldest preferred entry, else the oldest normal
// entry, else reports nobody waiting.
// Pipeline: queue memory read, then output register. Throughput: one item
// per cycle unless the result stalls, set by the single read and write
// port of each queue memory.
// A stalled result holds; one more item is taken into the read stage,
// then item_stall rises until the result beat completes.
// Reset (rst, synchronous) empties both queues and drops any pending
// result; queue memory contents are not cleared.
// Depends on tcpq_pkg, tcpq_ctl and tcpq_ram.
module two_class_priority_ticket_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        opcode,
  input  logic        preferred,
  input  logic [15:0] customer_id,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  status,
  output logic [15:0] ticket,
  output logic [15:0] served_customer,
  output logic        served_preferred,
  output logic [6:0]  preferred_count,
  output logic [6:0]  normal_count
);
  import tcpq_pkg::*;

  mem_req_t pref_req, norm_req;
  stage_t   stage;
  entry_t   pref_rd, norm_rd, hit;
  logic     stage_valid, out_free, accept;

  // handshake
  assign out_free   = !result_valid || !result_stall;
  assign item_stall = stage_valid && !out_free;
  assign accept     = item_valid && !item_stall;

  tcpq_ctl u_ctl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .opcode      (opcode),
    .preferred   (preferred),
    .customer_id (customer_id),
    .pref_req    (pref_req),
    .norm_req    (norm_req),
    .stage       (stage)
  );

  tcpq_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(ENTRY_W)) u_pref_ram (
    .clk   (clk),
    .we    (pref_req.we),
    .waddr (pref_req.waddr),
    .wdata (pref_req.wdata),
    .re    (pref_req.re),
    .raddr (pref_req.raddr),
    .rdata (pref_rd)
  );

  tcpq_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(ENTRY_W)) u_norm_ram (
    .clk   (clk),
    .we    (norm_req.we),
    .waddr (norm_req.waddr),
    .wdata (norm_req.wdata),
    .re    (norm_req.re),
    .raddr (norm_req.raddr),
    .rdata (norm_rd)
  );

  assign hit = stage.from_pref ? pref_rd : norm_rd;

  // read stage occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (out_free) begin
      stage_valid <= 1'b0;
    end
  end

  // output beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (stage_valid && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (stage_valid && out_free) begin
      status          <= stage.status;
      preferred_count <= COUNT_W'(stage.pref_fill);
      normal_count    <= COUNT_W'(stage.norm_fill);
      if (stage.status == ST_CALLED) begin
        ticket           <= hit.seq;
        served_customer  <= CUST_W'(hit.id);
        served_preferred <= stage.from_pref;
      end else begin
        ticket           <= stage.ticket;
        served_customer  <= '0;
        served_preferred <= 1'b0;
      end
    end
  end

endmodule

>>> sv/tcpq_ram.sv
// Generic single-write, single-read synchronous memory.
// Read data is registered and holds until the next read enable.
module tcpq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/tcpq_ctl.sv
// Queue control: head/tail pointers, fill counts and the sequence counter.
// Decides push, pop or reject per item and drives both queue memories.
// Depends on tcpq_pkg.
module tcpq_ctl (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              opcode,
  input  logic              preferred,
  input  logic [15:0]       customer_id,
  output tcpq_pkg::mem_req_t pref_req,
  output tcpq_pkg::mem_req_t norm_req,
  output tcpq_pkg::stage_t  stage
);
  import tcpq_pkg::*;

  ptr_t  pref_head, pref_tail, norm_head, norm_tail;
  ptr_t  pref_head_next, pref_tail_next, norm_head_next, norm_tail_next;
  fill_t pref_fill, norm_fill, pref_fill_next, norm_fill_next;
  seq_t  next_sequence, next_sequence_next;
  stage_t stage_next;
  entry_t new_entry;
  logic  pref_full, norm_full;

  assign new_entry = '{seq: next_sequence, id: ID_WIDTH'(customer_id)};
  assign pref_full = (pref_fill == FILL_W'(QUEUE_DEPTH));
  assign norm_full = (norm_fill == FILL_W'(QUEUE_DEPTH));

  // per-item decision
  always_comb begin
    pref_head_next     = pref_head;
    pref_tail_next     = pref_tail;
    norm_head_next     = norm_head;
    norm_tail_next     = norm_tail;
    pref_fill_next     = pref_fill;
    norm_fill_next     = norm_fill;
    next_sequence_next = next_sequence;
    pref_req           = '{we: 1'b0, waddr: pref_tail, wdata: new_entry,
                           re: 1'b0, raddr: pref_head};
    norm_req           = '{we: 1'b0, waddr: norm_tail, wdata: new_entry,
                           re: 1'b0, raddr: norm_head};
    stage_next.status    = ST_EMPTY;
    stage_next.ticket    = '0;
    stage_next.from_pref = 1'b0;

    if (accept) begin
      if (opcode == OP_ISSUE) begin
        if (preferred) begin
          if (pref_full) begin
            stage_next.status = ST_FULL;
          end else begin
            pref_req.we       = 1'b1;
            pref_tail_next    = ptr_adv(pref_tail);
            pref_fill_next    = pref_fill + fill_t'(1);
            stage_next.status = ST_ISSUED;
            stage_next.ticket = next_sequence;
            next_sequence_next = next_sequence + seq_t'(1);
          end
        end else begin
          if (norm_full) begin
            stage_next.status = ST_FULL;
          end else begin
            norm_req.we       = 1'b1;
            norm_tail_next    = ptr_adv(norm_tail);
            norm_fill_next    = norm_fill + fill_t'(1);
            stage_next.status = ST_ISSUED;
            stage_next.ticket = next_sequence;
            next_sequence_next = next_sequence + seq_t'(1);
          end
        end
      end else begin
        // strict priority: preferred queue first
        if (pref_fill != '0) begin
          pref_req.re          = 1'b1;
          pref_head_next       = ptr_adv(pref_head);
          pref_fill_next       = pref_fill - fill_t'(1);
          stage_next.status    = ST_CALLED;
          stage_next.from_pref = 1'b1;
        end else if (norm_fill != '0) begin
          norm_req.re       = 1'b1;
          norm_head_next    = ptr_adv(norm_head);
          norm_fill_next    = norm_fill - fill_t'(1);
          stage_next.status = ST_CALLED;
        end else begin
          stage_next.status = ST_EMPTY;
        end
      end
    end

    stage_next.pref_fill = pref_fill_next;
    stage_next.norm_fill = norm_fill_next;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pref_head     <= '0;
      pref_tail     <= '0;
      norm_head     <= '0;
      norm_tail     <= '0;
      pref_fill     <= '0;
      norm_fill     <= '0;
      next_sequence <= seq_t'(1);
    end else begin
      pref_head     <= pref_head_next;
      pref_tail     <= pref_tail_next;
      norm_head     <= norm_head_next;
      norm_tail     <= norm_tail_next;
      pref_fill     <= pref_fill_next;
      norm_fill     <= norm_fill_next;
      next_sequence <= next_sequence_next;
    end
  end

  // decision held while the memory read completes
  always_ff @(posedge clk) begin
    if (accept) begin
      stage <= stage_next;
    end
  end

endmodule

>>> sv/tcpq_checker.sv
// Port-level checks of the two-class priority ticket queue, bound to the
// top level. Depends on tcpq_pkg.
module tcpq_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_stall,
  input logic [1:0]  status,
  input logic [15:0] ticket,
  input logic [15:0] served_customer,
  input logic        served_preferred,
  input logic [6:0]  preferred_count,
  input logic [6:0]  normal_count
);
  import tcpq_pkg::*;

  // a stalled result beat stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result beat dropped while stalled");

  // nothing is offered right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result offered after reset");

  // nobody waiting means both queues are empty
  a_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == ST_EMPTY |->
      preferred_count == '0 && normal_count == '0 && ticket == '0)
    else $error("empty report with waiting entries");

  // a normal entry is served only when no preferred entry waits
  a_prio: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == ST_CALLED && !served_preferred |->
      preferred_count == '0)
    else $error("normal entry served ahead of preferred");

  // rejects carry no ticket and no customer
  a_full: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == ST_FULL |->
      ticket == '0 && served_customer == '0 && !served_preferred)
    else $error("rejected issue carries data");

endmodule

bind two_class_priority_ticket_queue tcpq_checker u_tcpq_checker (
  .clk              (clk),
  .rst              (rst),
  .result_valid     (result_valid),
  .result_stall     (result_stall),
  .status           (status),
  .ticket           (ticket),
  .served_customer  (served_customer),
  .served_preferred (served_preferred),
  .preferred_count  (preferred_count),
  .normal_count     (normal_count)
);

>>> tb/sv/tb.sv
// Self-checking bench for the two-class strict-priority ticket queue.
// Drives issue and call beats, predicts every result beat and compares it.
// Depends on tcpq_pkg and two_class_priority_ticket_queue.
module tb;
  import tcpq_pkg::*;

  localparam int RANDOM_ITEMS   = 1950;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int LONG_HOLD      = 200;
  localparam int MAX_REPORTS    = 10;

  // one result beat as the block presents it
  typedef struct packed {
    status_t    status;
    seq_t       ticket;
    logic [15:0] customer;
    logic       from_pref;
    count_t     pref_cnt;
    count_t     norm_cnt;
  } outcome_t;

  // one row of the directed table; typed rows carry their own result
  typedef struct packed {
    opcode_t  op;
    logic     pref;
    id_t      id;
    logic     typed;
    outcome_t want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic        opcode = 1'b0;
  logic        preferred = 1'b0;
  logic [15:0] customer_id = 16'h0000;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [1:0]  status;
  logic [15:0] ticket;
  logic [15:0] served_customer;
  logic        served_preferred;
  logic [6:0]  preferred_count;
  logic [6:0]  normal_count;

  // shadow queues and sequence counter of the predictor
  entry_t   pref_line[$];
  entry_t   norm_line[$];
  seq_t     seq_counter = 16'd1;

  // results still owed by the block, oldest first
  outcome_t pending_outcomes[$];
  int       outstanding = 0;

  int       errors = 0;
  int       beats_in = 0;
  int       status_seen[4] = '{0, 0, 0, 0};
  int       idle_pct = 30;
  int       rx_idle_pct = 30;
  bit       hold_request = 1'b0;
  int       long_holds = 0;
  int       pauses = 0;
  int       quiet_cycles = 0;

  two_class_priority_ticket_queue u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // idle length: none with chance (100 - pct) percent, else mostly short, a few long
  function automatic int idle_gap(input int pct);
    int r;
    if ($urandom_range(99, 0) >= pct) return 0;
    r = $urandom_range(99, 0);
    if (r < 70) return $urandom_range(3, 1);
    if (r < 95) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  // work out the result of one accepted beat and update the shadow state
  function automatic outcome_t queue_outcome(input opcode_t op, input logic pref,
                                             input id_t id);
    outcome_t r;
    entry_t   e;
    r = '0;
    if (op == OP_ISSUE) begin
      if (pref ? (pref_line.size() >= QUEUE_DEPTH) : (norm_line.size() >= QUEUE_DEPTH)) begin
        r.status = ST_FULL;
      end else begin
        e.seq = seq_counter;
        e.id  = id;
        if (pref) pref_line.push_back(e);
        else norm_line.push_back(e);
        r.status = ST_ISSUED;
        r.ticket = seq_counter;
        seq_counter = seq_counter + seq_t'(1);
      end
    end else if (pref_line.size() > 0) begin
      e = pref_line.pop_front();
      r.status    = ST_CALLED;
      r.ticket    = e.seq;
      r.customer  = e.id;
      r.from_pref = 1'b1;
    end else if (norm_line.size() > 0) begin
      e = norm_line.pop_front();
      r.status   = ST_CALLED;
      r.ticket   = e.seq;
      r.customer = e.id;
    end else begin
      r.status = ST_EMPTY;
    end
    r.pref_cnt = count_t'(pref_line.size());
    r.norm_cnt = count_t'(norm_line.size());
    return r;
  endfunction

  // present one item beat after a random gap, record its expected result
  task automatic offer_beat(input opcode_t op, input logic pref, input id_t id,
                            input logic typed, input outcome_t want);
    int       gap;
    outcome_t predicted;
    gap = idle_gap(idle_pct);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid  <= 1'b1;
    opcode      <= op;
    preferred   <= pref;
    customer_id <= id;
    do @(posedge clk); while (item_stall);
    predicted = queue_outcome(op, pref, id);
    pending_outcomes.push_back(typed ? want : predicted);
    outstanding++;
    beats_in++;
    @(negedge clk);
  endtask

  // result side stall pattern, with one long hold-off on request
  initial begin
    int hold;
    int free;
    @(negedge clk);
    forever begin
      hold = idle_gap(rx_idle_pct);
      if (hold_request) begin
        hold = LONG_HOLD;
        hold_request = 1'b0;
        long_holds++;
      end
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      result_stall <= 1'b0;
      free = $urandom_range(8, 1);
      repeat (free) @(negedge clk);
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (!rst && result_valid && !result_stall) begin
      got.status    = status_t'(status);
      got.ticket    = ticket;
      got.customer  = served_customer;
      got.from_pref = served_preferred;
      got.pref_cnt  = preferred_count;
      got.norm_cnt  = normal_count;
      if (outstanding == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result beat with nothing expected, status=%0d ticket=%0d",
                   $time, got.status, got.ticket);
      end else begin
        want = pending_outcomes.pop_front();
        outstanding--;
        status_seen[int'(want.status)]++;
        if (got !== want) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display({"%0t: mismatch want st=%0d tk=%0d cust=%h pref=%0b pc=%0d nc=%0d",
                      " got st=%0d tk=%0d cust=%h pref=%0b pc=%0d nc=%0d"},
                     $time, want.status, want.ticket, want.customer, want.from_pref,
                     want.pref_cnt, want.norm_cnt, got.status, got.ticket, got.customer,
                     got.from_pref, got.pref_cnt, got.norm_cnt);
        end
      end
    end
  end

  // watchdog on cycles without any beat on either side
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results owed",
               quiet_cycles, outstanding);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus
  initial begin
    plan_row_t plan [19];
    int        n;
    int        i;
    int        len;
    int        mode;
    int        issue_pct;
    int        pct_pick;
    logic      cls;
    bit        fill_mode;
    bit        hold_done;
    opcode_t   op;

    // empty calls, both classes, id extremes, priority order, ignored call fields
    plan = '{
      '{OP_CALL,  1'b0, 16'h0000, 1'b1, '{ST_EMPTY,  16'd0, 16'h0000, 1'b0, 7'd0, 7'd0}},
      '{OP_CALL,  1'b1, 16'hFFFF, 1'b1, '{ST_EMPTY,  16'd0, 16'h0000, 1'b0, 7'd0, 7'd0}},
      '{OP_ISSUE, 1'b0, 16'h0000, 1'b1, '{ST_ISSUED, 16'd1, 16'h0000, 1'b0, 7'd0, 7'd1}},
      '{OP_ISSUE, 1'b1, 16'hFFFF, 1'b1, '{ST_ISSUED, 16'd2, 16'h0000, 1'b0, 7'd1, 7'd1}},
      '{OP_ISSUE, 1'b0, 16'hA5A5, 1'b1, '{ST_ISSUED, 16'd3, 16'h0000, 1'b0, 7'd1, 7'd2}},
      '{OP_ISSUE, 1'b1, 16'h5A5A, 1'b1, '{ST_ISSUED, 16'd4, 16'h0000, 1'b0, 7'd2, 7'd2}},
      '{OP_CALL,  1'b0, 16'h1234, 1'b1, '{ST_CALLED, 16'd2, 16'hFFFF, 1'b1, 7'd1, 7'd2}},
      '{OP_CALL,  1'b1, 16'h0000, 1'b1, '{ST_CALLED, 16'd4, 16'h5A5A, 1'b1, 7'd0, 7'd2}},
      '{OP_CALL,  1'b0, 16'hFFFF, 1'b1, '{ST_CALLED, 16'd1, 16'h0000, 1'b0, 7'd0, 7'd1}},
      '{OP_ISSUE, 1'b1, 16'h8001, 1'b1, '{ST_ISSUED, 16'd5, 16'h0000, 1'b0, 7'd1, 7'd1}},
      '{OP_CALL,  1'b1, 16'hFFFF, 1'b1, '{ST_CALLED, 16'd5, 16'h8001, 1'b1, 7'd0, 7'd1}},
      '{OP_CALL,  1'b0, 16'h0000, 1'b1, '{ST_CALLED, 16'd3, 16'hA5A5, 1'b0, 7'd0, 7'd0}},
      '{OP_CALL,  1'b1, 16'h7777, 1'b1, '{ST_EMPTY,  16'd0, 16'h0000, 1'b0, 7'd0, 7'd0}},
      '{OP_ISSUE, 1'b0, 16'h7FFE, 1'b0, '0},
      '{OP_ISSUE, 1'b1, 16'h0001, 1'b0, '0},
      '{OP_ISSUE, 1'b0, 16'hFFFF, 1'b0, '0},
      '{OP_CALL,  1'b0, 16'hFFFF, 1'b0, '0},
      '{OP_CALL,  1'b1, 16'h8000, 1'b0, '0},
      '{OP_CALL,  1'b0, 16'h0000, 1'b0, '0}
    };
    hold_done = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    for (i = 0; i < 19; i++)
      offer_beat(plan[i].op, plan[i].pref, plan[i].id, plan[i].typed, plan[i].want);

    // random bursts: mixed traffic, class fills to overflow, drains, pauses
    n = 0;
    while (n < RANDOM_ITEMS) begin
      mode      = $urandom_range(9, 0);
      pct_pick  = $urandom_range(2, 0);
      idle_pct  = (pct_pick == 0) ? 0 : (pct_pick == 1) ? 25 : 70;
      pct_pick  = $urandom_range(2, 0);
      rx_idle_pct = (pct_pick == 0) ? 0 : (pct_pick == 1) ? 25 : 70;
      if (!hold_done && n >= 600) begin
        hold_request = 1'b1;
        hold_done    = 1'b1;
        idle_pct     = 0;
        mode         = 8;
      end else if (pauses == 0 && n >= 1200) begin
        mode = 9;
      end
      fill_mode = 1'b0;
      cls       = 1'($urandom_range(1, 0));
      len       = 0;
      issue_pct = 50;
      case (mode)
        4, 5: begin
          fill_mode = 1'b1;
          issue_pct = 100;
          len       = $urandom_range(75, 60);
        end
        6, 7: begin
          issue_pct = 0;
          len       = pref_line.size() + norm_line.size() + $urandom_range(3, 1);
        end
        8: begin
          issue_pct = 75;
          len       = $urandom_range(60, 20);
        end
        9: begin
          // sender holds off until every owed result is back
          item_valid <= 1'b0;
          wait (outstanding == 0);
          @(negedge clk);
          pauses++;
        end
        default: len = $urandom_range(40, 10);
      endcase
      for (i = 0; i < len; i++) begin
        op = ($urandom_range(99, 0) < issue_pct) ? OP_ISSUE : OP_CALL;
        offer_beat(op, fill_mode ? cls : 1'($urandom_range(1, 0)),
                   id_t'($urandom), 1'b0, '0);
        n++;
      end
    end

    // wind down and report
    item_valid <= 1'b0;
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (outstanding != 0) errors++;
    $display("run: %0d item beats, %0d issued, %0d called, %0d nobody waiting, %0d full",
             beats_in, status_seen[ST_ISSUED], status_seen[ST_CALLED],
             status_seen[ST_EMPTY], status_seen[ST_FULL]);
    $display("run: %0d long result hold-offs, %0d sender pauses until drained",
             long_holds, pauses);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
